/* rtl/saa_pkg.sv */
// Shared types and constants for the stack arena allocator.
// Stand-alone package; used by the top level by scoped names.
package saa_pkg;

  // Arena geometry.
  localparam int unsigned ARENA_BYTES  = 4096;
  localparam int unsigned HEADER_BYTES = 1;
  localparam int unsigned SLOT_W       = $clog2(ARENA_BYTES);

  // Field and state widths.
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned ALIGN_W = 8;
  localparam int unsigned GAP_W   = 8;
  localparam int unsigned WORK_W  = 12;
  localparam int unsigned NEED_W  = 18;
  localparam int unsigned CFG_W   = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Request codes.
  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_BAD_SIZE     = 3'd2,
    ST_BAD_ALIGN    = 3'd3,
    ST_OUT_OF_BOUND = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_BASE_ADDRESS = 1'b0,
    CFG_ARENA_SIZE   = 1'b1
  } cfg_idx_t;

endpackage

/* rtl/saa_ram.sv */
// Generic single-clock RAM: one write port and one read port with registered read data.
// No dependencies.
module saa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/stack_arena_allocator.sv */
// Stack arena allocator top level: request sequencing, arithmetic and result register.
// Depends on saa_pkg and saa_ram.

// Each request goes from S_IDLE to S_EXEC: at the accepting edge the header gap of the
// block to be freed is read into the registered gap memory output, and in S_EXEC the
// request is executed and its result beat is loaded into the output register. A new
// request is accepted on the cycle after the execute edge, even while the previous result
// beat is still stalled; a request waits in its execute cycle only if the output register
// is still full. The gap memory holds no reset value and needs no clearing pass, so the
// block is ready straight after reset. Configuration writes are expected only while idle.
module stack_arena_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration port
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [saa_pkg::CFG_W-1:0]    cfg_wdata,
  // Request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_func,
  input  logic [saa_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [saa_pkg::ALIGN_W-1:0]  in_alignment,
  input  logic [saa_pkg::ADDR_W-1:0]   in_free_address,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_status,
  output logic [saa_pkg::ADDR_W-1:0]   out_block_address,
  output logic [saa_pkg::CNT_W-1:0]    out_used_now,
  output logic [saa_pkg::CNT_W-1:0]    out_live_blocks
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                         state_r, state_nxt;

  // Configuration registers.
  logic [saa_pkg::ADDR_W-1:0]     base_r;
  logic [saa_pkg::CNT_W-1:0]      arena_size_r;

  // Allocator state.
  logic [saa_pkg::CNT_W-1:0]      used_r, used_nxt;
  logic [saa_pkg::CNT_W-1:0]      count_r, count_nxt;

  // Latched request.
  saa_pkg::func_t                 func_r;
  logic [saa_pkg::SIZE_W-1:0]     size_r;
  logic [saa_pkg::ALIGN_W-1:0]    align_r;
  logic [saa_pkg::ADDR_W-1:0]     off_r;

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  saa_pkg::status_t               status_r, status_nxt;
  logic [saa_pkg::ADDR_W-1:0]     blk_r, blk_nxt;

  logic                           in_accept;
  logic                           exec_done;
  logic [saa_pkg::ADDR_W-1:0]     in_off;

  // Gap memory ports.
  logic                           gap_we;
  logic [saa_pkg::SLOT_W-1:0]     gap_waddr;
  logic [saa_pkg::SLOT_W-1:0]     gap_raddr;
  logic [saa_pkg::GAP_W-1:0]      gap_rdata;

  // Allocate arithmetic.
  logic [saa_pkg::CNT_W-1:0]      limit;
  logic [saa_pkg::ADDR_W-1:0]     top_addr;
  logic [saa_pkg::ALIGN_W-1:0]    align_m1;
  logic                           align_ok;
  logic [2:0]                     align_lg;
  logic [saa_pkg::WORK_W-1:0]     adj;
  logic [saa_pkg::WORK_W-1:0]     rest;
  logic [saa_pkg::WORK_W-1:0]     steps;
  logic [saa_pkg::WORK_W-1:0]     gap;
  logic [saa_pkg::NEED_W-1:0]     need;
  logic [saa_pkg::CNT_W-1:0]      slot_sum;

  // Free arithmetic.
  logic                           free_oob;

  // Handshake.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // Offset of the block to free, and the header slot read at the accepting edge.
  assign in_off    = in_free_address - base_r;
  assign gap_raddr = saa_pkg::SLOT_W'(in_off - saa_pkg::ADDR_W'(saa_pkg::HEADER_BYTES));

  // Effective arena limit.
  assign limit = (arena_size_r > saa_pkg::CNT_W'(saa_pkg::ARENA_BYTES)) ?
                 saa_pkg::CNT_W'(saa_pkg::ARENA_BYTES) : arena_size_r;

  // Gap that aligns the new block and leaves room for its header.
  always_comb begin
    top_addr = base_r + saa_pkg::ADDR_W'(used_r);
    align_m1 = align_r - saa_pkg::ALIGN_W'(1);
    align_ok = (align_r != '0) && ((align_r & align_m1) == '0);
    align_lg = '0;
    for (int i = 0; i < saa_pkg::ALIGN_W; i++) begin
      if (align_r[i]) begin
        align_lg = 3'(i);
      end
    end
    adj   = saa_pkg::WORK_W'((-top_addr[saa_pkg::ALIGN_W-1:0]) & align_m1);
    rest  = (adj < saa_pkg::WORK_W'(saa_pkg::HEADER_BYTES)) ?
            saa_pkg::WORK_W'(saa_pkg::HEADER_BYTES) - adj : '0;
    steps = (rest + saa_pkg::WORK_W'(align_m1)) >> align_lg;
    gap   = adj + (steps << align_lg);
    need  = saa_pkg::NEED_W'(used_r) + saa_pkg::NEED_W'(gap) + saa_pkg::NEED_W'(size_r);
    slot_sum = used_r + saa_pkg::CNT_W'(gap) - saa_pkg::CNT_W'(saa_pkg::HEADER_BYTES);
  end

  // Free bounds check against the stored header gap.
  assign free_oob = (off_r >= saa_pkg::ADDR_W'(used_r)) ||
                    (off_r < saa_pkg::ADDR_W'(saa_pkg::HEADER_BYTES)) ||
                    (saa_pkg::ADDR_W'(gap_rdata) > off_r);

  // Execute: next state of the allocator and the result beat.
  always_comb begin
    used_nxt   = used_r;
    count_nxt  = count_r;
    status_nxt = saa_pkg::ST_OK;
    blk_nxt    = '0;
    gap_we     = 1'b0;
    gap_waddr  = slot_sum[saa_pkg::SLOT_W-1:0];
    case (func_r)
      saa_pkg::FN_ALLOC: begin
        if (size_r == '0) begin
          status_nxt = saa_pkg::ST_BAD_SIZE;
        end else if (!align_ok) begin
          status_nxt = saa_pkg::ST_BAD_ALIGN;
        end else if (need > saa_pkg::NEED_W'(limit)) begin
          status_nxt = saa_pkg::ST_NO_SPACE;
        end else begin
          gap_we    = exec_done;
          used_nxt  = saa_pkg::CNT_W'(need);
          count_nxt = (count_r == saa_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
          blk_nxt   = top_addr + saa_pkg::ADDR_W'(gap);
        end
      end
      saa_pkg::FN_FREE: begin
        if (free_oob) begin
          status_nxt = saa_pkg::ST_OUT_OF_BOUND;
        end else begin
          used_nxt  = saa_pkg::CNT_W'(off_r) - saa_pkg::CNT_W'(gap_rdata);
          count_nxt = (count_r == '0) ? count_r : count_r - 1'b1;
        end
      end
      saa_pkg::FN_CLEAR: begin
        used_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          out_valid_nxt = out_valid_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, allocator registers and the registered result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      used_r       <= '0;
      count_r      <= '0;
      base_r       <= '0;
      arena_size_r <= saa_pkg::CNT_W'(saa_pkg::ARENA_BYTES);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_done) begin
        used_r  <= used_nxt;
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        case (saa_pkg::cfg_idx_t'(cfg_index))
          saa_pkg::CFG_BASE_ADDRESS: base_r       <= cfg_wdata;
          saa_pkg::CFG_ARENA_SIZE:   arena_size_r <= cfg_wdata[saa_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r  <= saa_pkg::func_t'(in_func);
      size_r  <= in_request_size;
      align_r <= in_alignment;
      off_r   <= in_off;
    end
    if (exec_done) begin
      status_r <= status_nxt;
      blk_r    <= blk_nxt;
    end
  end

  // Header gap memory, one entry per arena byte.
  saa_ram #(
    .WIDTH (saa_pkg::GAP_W),
    .DEPTH (saa_pkg::ARENA_BYTES)
  ) u_gap_ram (
    .clk   (clk),
    .we    (gap_we),
    .waddr (gap_waddr),
    .wdata (gap[saa_pkg::GAP_W-1:0]),
    .re    (in_accept),
    .raddr (gap_raddr),
    .rdata (gap_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_block_address = blk_r;
  assign out_used_now      = used_r;
  assign out_live_blocks   = count_r;

  // The used count never runs past the arena.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= saa_pkg::CNT_W'(saa_pkg::ARENA_BYTES))
    else $error("used count beyond arena");

  // A gap read is always followed by an execute cycle that consumes it.
  a_read_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_EXEC))
    else $error("gap read without execute");

  // Gap writes come only from a completing allocate, never alongside a read.
  a_write_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    gap_we |-> (exec_done && func_r == saa_pkg::FN_ALLOC && !in_accept))
    else $error("stray gap write");

  // A completed execute always presents a result beat.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_done |=> out_valid_r)
    else $error("result beat lost");

  // Only a successful allocate carries a block address.
  a_blk_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && blk_r != '0) |-> (status_r == saa_pkg::ST_OK))
    else $error("block address on failed request");

endmodule
